FILE: src/frame_rotate_vector_slew_limiter_unit_defines.svh
// assertion macros shared by the slew limiter modules
`ifndef FRAME_ROTATE_VECTOR_SLEW_LIMITER_UNIT_DEFINES_SVH
`define FRAME_ROTATE_VECTOR_SLEW_LIMITER_UNIT_DEFINES_SVH

// plain property check on the rising clock edge, off during reset
`define FVSL_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication check built on the plain form
`define FVSL_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   `FVSL_ASSERT(name, clk, rst, (ante) |-> (cons), msg)

`endif

FILE: src/fvsl_pkg.sv
// package: constants, types and helper functions of the slew limiter
`timescale 1ns / 1ps
package fvsl_pkg;

   localparam int FRAC_BITS_DEF = 8;
   localparam int STEP_RESET_MULT = 3;
   localparam int CORDIC_STAGES = 16;
   localparam int GUARD_BITS = 14;
   localparam int INV_GAIN = 39797;

   localparam int VW = 16;   // velocity field width
   localparam int MW = 15;   // max step width
   localparam int CW = 33;   // cordic x/y width
   localparam int ZW = 18;   // cordic angle width
   localparam int RW = 20;   // rotated value and difference width
   localparam int SW = 40;   // squared length width
   localparam int QW = 28;   // root / quotient register width
   localparam int OPW = 56;  // root radicand width
   localparam int DW = 44;   // remainder and numerator width
   localparam int AW = 34;   // multiplier operand a
   localparam int BW = 21;   // multiplier operand b
   localparam int PW = AW + BW;
   localparam int ROOT_ITER = 28;
   localparam int DIV_ITER = 16;

   typedef enum logic {
      RD_ROOT,
      RD_DIV
   } rd_mode_type;

   typedef struct packed {
      logic        start;
      rd_mode_type mode;
   } rd_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } rd_status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_MUL_X,
      ST_MUL_Y,
      ST_DIFF,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SUM,
      ST_DECIDE,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_MX,
      ST_DIVX_GO,
      ST_DIVX_WAIT,
      ST_MY,
      ST_DIVY_GO,
      ST_DIVY_WAIT,
      ST_UPDATE
   } fvsl_state_type;

   // arctangent of 2^-i in binary-angle units
   function automatic logic [13:0] atan_val(input logic [3:0] idx);
      logic [13:0] v;
      case (idx)
         4'd0:    v = 14'd8192;
         4'd1:    v = 14'd4836;
         4'd2:    v = 14'd2555;
         4'd3:    v = 14'd1297;
         4'd4:    v = 14'd651;
         4'd5:    v = 14'd326;
         4'd6:    v = 14'd163;
         4'd7:    v = 14'd81;
         4'd8:    v = 14'd41;
         4'd9:    v = 14'd20;
         4'd10:   v = 14'd10;
         4'd11:   v = 14'd5;
         4'd12:   v = 14'd3;
         4'd13:   v = 14'd1;
         4'd14:   v = 14'd1;
         default: v = 14'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [VW-1:0] sat16(input logic signed [RW:0] v);
      logic signed [VW-1:0] r;
      if (v > 21'sd32767) begin
         r = 16'sd32767;
      end else if (v < -21'sd32768) begin
         r = -16'sd32768;
      end else begin
         r = v[VW-1:0];
      end
      return r;
   endfunction

endpackage

FILE: src/fvsl_cordic.sv
// iterative cordic rotating the command vector by minus the heading
`timescale 1ns / 1ps
`include "frame_rotate_vector_slew_limiter_unit_defines.svh"
module fvsl_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [fvsl_pkg::VW-1:0]      vel_x,
   input  logic signed [fvsl_pkg::VW-1:0]      vel_y,
   input  logic        [fvsl_pkg::VW-1:0]      heading,
   output logic                                done,
   output logic signed [fvsl_pkg::CW-1:0]      x_out,
   output logic signed [fvsl_pkg::CW-1:0]      y_out
);

   logic                               run_ff, run_in;
   logic                               done_ff, done_in;
   logic [3:0]                         cnt_ff, cnt_in;
   logic signed [fvsl_pkg::CW-1:0]     x_ff, x_in, y_ff, y_in;
   logic signed [fvsl_pkg::ZW-1:0]     z_ff, z_in;

   logic        [fvsl_pkg::VW-1:0]     ang;
   logic signed [fvsl_pkg::ZW-1:0]     z0;
   logic signed [fvsl_pkg::CW-1:0]     x0, y0, xs, ys;
   logic signed [fvsl_pkg::ZW-1:0]     at;

   always_comb begin
      ang = 16'(17'd0 - {1'b0, heading});
      z0  = {{2{ang[15]}}, ang};
      x0  = {{3{vel_x[15]}}, vel_x, 14'd0};
      y0  = {{3{vel_y[15]}}, vel_y, 14'd0};
      xs  = x_ff >>> cnt_ff;
      ys  = y_ff >>> cnt_ff;
      at  = {4'd0, fvsl_pkg::atan_val(cnt_ff)};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         // fold the angle into the half turn the iterations converge on
         if (z0 > 18'sd16384) begin
            x_in = -x0;
            y_in = -y0;
            z_in = z0 - 18'sd32768;
         end else if (z0 < -18'sd16384) begin
            x_in = -x0;
            y_in = -y0;
            z_in = z0 + 18'sd32768;
         end else begin
            x_in = x0;
            y_in = y0;
            z_in = z0;
         end
      end else if (run_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(fvsl_pkg::CORDIC_STAGES - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign done  = done_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;

   `FVSL_ASSERT_IMP(a_z_bounded, clock, reset, run_ff && !start, (z_ff <= 18'sd24576) && (z_ff >= -18'sd24576), "cordic angle out of range")

endmodule

FILE: src/fvsl_root_div.sv
// shared compare and subtract unit: bitwise square root and long division
`timescale 1ns / 1ps
`include "frame_rotate_vector_slew_limiter_unit_defines.svh"
module fvsl_root_div (
   input  logic                           clock,
   input  logic                           reset,
   input  fvsl_pkg::rd_cmd_type           cmd,
   input  logic [fvsl_pkg::OPW-1:0]       opa,
   input  logic [fvsl_pkg::QW-1:0]        opb,
   output fvsl_pkg::rd_status_type        status,
   output logic [fvsl_pkg::QW-1:0]        result
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   fvsl_pkg::rd_mode_type         mode_ff, mode_in;
   logic [4:0]                    cnt_ff, cnt_in;
   logic [fvsl_pkg::DW-1:0]       rem_ff, rem_in;
   logic [fvsl_pkg::DW-1:0]       den_ff, den_in;
   logic [fvsl_pkg::OPW-1:0]      rad_ff, rad_in;
   logic [fvsl_pkg::QW-1:0]       q_ff, q_in;

   logic [fvsl_pkg::DW-1:0]       cand, trial;
   logic                          ge;

   always_comb begin
      if (mode_ff == fvsl_pkg::RD_ROOT) begin
         cand  = {rem_ff[fvsl_pkg::DW-3:0], rad_ff[fvsl_pkg::OPW-1 -: 2]};
         trial = {14'd0, q_ff, 2'b01};
      end else begin
         cand  = rem_ff;
         trial = den_ff;
      end
      ge = (cand >= trial);

      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      rad_in  = rad_ff;
      q_in    = q_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         mode_in = cmd.mode;
         q_in    = '0;
         rad_in  = opa;
         if (cmd.mode == fvsl_pkg::RD_ROOT) begin
            rem_in = '0;
            cnt_in = 5'(fvsl_pkg::ROOT_ITER - 1);
         end else begin
            rem_in = opa[fvsl_pkg::DW-1:0];
            cnt_in = 5'(fvsl_pkg::DIV_ITER - 1);
         end
         // divisor starts aligned with the top quotient bit
         den_in = {1'b0, opb, 15'd0};
      end else if (busy_ff) begin
         rem_in = ge ? (cand - trial) : cand;
         q_in   = {q_ff[fvsl_pkg::QW-2:0], ge};
         rad_in = {rad_ff[fvsl_pkg::OPW-3:0], 2'b00};
         den_in = {1'b0, den_ff[fvsl_pkg::DW-1:1]};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         mode_ff <= fvsl_pkg::RD_ROOT;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      rad_ff <= rad_in;
      q_ff   <= q_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign result      = q_ff;

   `FVSL_ASSERT_IMP(a_done_idle, clock, reset, done_ff, !busy_ff, "done raised while still iterating")

endmodule

FILE: src/frame_rotate_vector_slew_limiter_unit.sv
// top level: sequencer, shared multiplier and state of the slew limiter
//
//  channel   ports                          direction
//  request   req_valid / req_stall, fields  in
//  response  rsp_valid / rsp_stall, fields  out
//  csr       csr_wr_en, csr_wr_data         in
//
// one item at a time; a step within the limit goes straight to update, a step
// that has to be scaled also runs the 28-step square root and two 16-step
// divisions on the shared unit, after the 16 cordic iterations of every item.
// reset clears the stored velocity and sets max step to three.
// the next item is taken once the result sits in the output register;
// a result waiting on rsp_stall holds the following item in its update state.
`timescale 1ns / 1ps
`include "frame_rotate_vector_slew_limiter_unit_defines.svh"
module frame_rotate_vector_slew_limiter_unit #(
   parameter int FRAC_BITS = fvsl_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [fvsl_pkg::VW-1:0]    req_vel_x_world,
   input  logic signed [fvsl_pkg::VW-1:0]    req_vel_y_world,
   input  logic signed [fvsl_pkg::VW-1:0]    req_ang_rate,
   input  logic        [fvsl_pkg::VW-1:0]    req_heading,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [fvsl_pkg::VW-1:0]    rsp_vel_x_out,
   output logic signed [fvsl_pkg::VW-1:0]    rsp_vel_y_out,
   output logic signed [fvsl_pkg::VW-1:0]    rsp_ang_rate_out,
   input  logic                              csr_wr_en,
   input  logic        [fvsl_pkg::MW-1:0]    csr_wr_data
);

   localparam int STEP_RESET_WIDE = fvsl_pkg::STEP_RESET_MULT << FRAC_BITS;
   localparam logic [fvsl_pkg::MW-1:0] STEP_RESET = STEP_RESET_WIDE[fvsl_pkg::MW-1:0];

   fvsl_pkg::fvsl_state_type state_ff, state_in;

   logic [fvsl_pkg::MW-1:0]             max_step_ff, max_step_in;
   logic signed [fvsl_pkg::VW-1:0]      last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic signed [fvsl_pkg::VW-1:0]      rate_ff;
   logic signed [fvsl_pkg::PW-1:0]      prod_ff;
   logic signed [fvsl_pkg::RW-1:0]      rx_ff, ry_ff, dx_ff, dy_ff;
   logic [fvsl_pkg::SW-1:0]             r2_ff;
   logic [29:0]                         lim2_ff;
   logic [fvsl_pkg::QW-1:0]             rq_ff;
   logic [15:0]                         qx_ff, qy_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [fvsl_pkg::VW-1:0]      out_x_ff, out_y_ff, out_rate_ff;

   logic                                accept, out_free;
   logic                                cordic_done;
   logic signed [fvsl_pkg::CW-1:0]      cx, cy;
   fvsl_pkg::rd_cmd_type                rd_cmd;
   fvsl_pkg::rd_status_type             rd_status;
   logic [fvsl_pkg::OPW-1:0]            rd_opa;
   logic [fvsl_pkg::QW-1:0]             rd_result;
   logic signed [fvsl_pkg::AW-1:0]      mul_a;
   logic signed [fvsl_pkg::BW-1:0]      mul_b;
   logic signed [fvsl_pkg::PW-1:0]      rnd;
   logic signed [fvsl_pkg::RW-1:0]      rnd_val;
   logic [fvsl_pkg::RW-1:0]             abs_dx, abs_dy;
   logic [fvsl_pkg::DW-1:0]             num;
   logic signed [fvsl_pkg::RW:0]        step_x, step_y, nx, ny;

   function automatic logic [fvsl_pkg::RW-1:0] RW_NEG(input logic [fvsl_pkg::RW-1:0] v);
      return fvsl_pkg::RW'(~v + 1'b1);
   endfunction

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   fvsl_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .vel_x   (req_vel_x_world),
      .vel_y   (req_vel_y_world),
      .heading (req_heading),
      .done    (cordic_done),
      .x_out   (cx),
      .y_out   (cy)
   );

   fvsl_root_div u_root_div (
      .clock  (clock),
      .reset  (reset),
      .cmd    (rd_cmd),
      .opa    (rd_opa),
      .opb    (rq_ff),
      .status (rd_status),
      .result (rd_result)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fvsl_pkg::ST_IDLE:      if (accept) state_in = fvsl_pkg::ST_CORDIC;
         fvsl_pkg::ST_CORDIC:    if (cordic_done) state_in = fvsl_pkg::ST_MUL_X;
         fvsl_pkg::ST_MUL_X:     state_in = fvsl_pkg::ST_MUL_Y;
         fvsl_pkg::ST_MUL_Y:     state_in = fvsl_pkg::ST_DIFF;
         fvsl_pkg::ST_DIFF:      state_in = fvsl_pkg::ST_SQ_X;
         fvsl_pkg::ST_SQ_X:      state_in = fvsl_pkg::ST_SQ_Y;
         fvsl_pkg::ST_SQ_Y:      state_in = fvsl_pkg::ST_SUM;
         fvsl_pkg::ST_SUM:       state_in = fvsl_pkg::ST_DECIDE;
         fvsl_pkg::ST_DECIDE: begin
            if (r2_ff > {10'd0, lim2_ff}) begin
               state_in = fvsl_pkg::ST_ROOT_GO;
            end else begin
               state_in = fvsl_pkg::ST_UPDATE;
            end
         end
         fvsl_pkg::ST_ROOT_GO:   state_in = fvsl_pkg::ST_ROOT_WAIT;
         fvsl_pkg::ST_ROOT_WAIT: if (rd_status.done) state_in = fvsl_pkg::ST_MX;
         fvsl_pkg::ST_MX:        state_in = fvsl_pkg::ST_DIVX_GO;
         fvsl_pkg::ST_DIVX_GO:   state_in = fvsl_pkg::ST_DIVX_WAIT;
         fvsl_pkg::ST_DIVX_WAIT: if (rd_status.done) state_in = fvsl_pkg::ST_MY;
         fvsl_pkg::ST_MY:        state_in = fvsl_pkg::ST_DIVY_GO;
         fvsl_pkg::ST_DIVY_GO:   state_in = fvsl_pkg::ST_DIVY_WAIT;
         fvsl_pkg::ST_DIVY_WAIT: if (rd_status.done) state_in = fvsl_pkg::ST_UPDATE;
         fvsl_pkg::ST_UPDATE:    if (out_free) state_in = fvsl_pkg::ST_IDLE;
         default:                state_in = fvsl_pkg::ST_IDLE;
      endcase
   end

   // control outputs: multiplier operands and shared unit commands
   always_comb begin
      abs_dx = dx_ff[fvsl_pkg::RW-1] ? RW_NEG(dx_ff) : dx_ff;
      abs_dy = dy_ff[fvsl_pkg::RW-1] ? RW_NEG(dy_ff) : dy_ff;
      mul_a  = '0;
      mul_b  = '0;
      rd_cmd.start = 1'b0;
      rd_cmd.mode  = fvsl_pkg::RD_ROOT;
      num    = {prod_ff[35:0], 8'd0} + {17'd0, rq_ff[fvsl_pkg::QW-1:1]};
      rd_opa = {r2_ff, 16'd0};
      case (state_ff)
         fvsl_pkg::ST_MUL_X: begin
            mul_a = {cx[fvsl_pkg::CW-1], cx};
            mul_b = 21'(fvsl_pkg::INV_GAIN);
         end
         fvsl_pkg::ST_MUL_Y: begin
            mul_a = {cy[fvsl_pkg::CW-1], cy};
            mul_b = 21'(fvsl_pkg::INV_GAIN);
         end
         fvsl_pkg::ST_DIFF: begin
            mul_a = {19'd0, max_step_ff};
            mul_b = {6'd0, max_step_ff};
         end
         fvsl_pkg::ST_SQ_X: begin
            mul_a = {{14{dx_ff[fvsl_pkg::RW-1]}}, dx_ff};
            mul_b = {dx_ff[fvsl_pkg::RW-1], dx_ff};
         end
         fvsl_pkg::ST_SQ_Y: begin
            mul_a = {{14{dy_ff[fvsl_pkg::RW-1]}}, dy_ff};
            mul_b = {dy_ff[fvsl_pkg::RW-1], dy_ff};
         end
         fvsl_pkg::ST_ROOT_GO: begin
            rd_cmd.start = 1'b1;
            rd_cmd.mode  = fvsl_pkg::RD_ROOT;
         end
         fvsl_pkg::ST_MX: begin
            mul_a = {14'd0, abs_dx};
            mul_b = {6'd0, max_step_ff};
         end
         fvsl_pkg::ST_MY: begin
            mul_a = {14'd0, abs_dy};
            mul_b = {6'd0, max_step_ff};
         end
         fvsl_pkg::ST_DIVX_GO, fvsl_pkg::ST_DIVY_GO: begin
            rd_cmd.start = 1'b1;
            rd_cmd.mode  = fvsl_pkg::RD_DIV;
            rd_opa       = {12'd0, num};
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // round the gain-corrected product half up down to the velocity format
   always_comb begin
      rnd     = prod_ff + (55'sd1 <<< 29);
      rnd_val = rnd[49:30];
      step_x  = dx_ff[fvsl_pkg::RW-1] ? -$signed({5'd0, qx_ff}) : $signed({5'd0, qx_ff});
      step_y  = dy_ff[fvsl_pkg::RW-1] ? -$signed({5'd0, qy_ff}) : $signed({5'd0, qy_ff});
      if (rq_ff != '0 && r2_ff > {10'd0, lim2_ff}) begin
         nx = {{5{last_x_ff[15]}}, last_x_ff} + step_x;
         ny = {{5{last_y_ff[15]}}, last_y_ff} + step_y;
      end else begin
         nx = {rx_ff[fvsl_pkg::RW-1], rx_ff};
         ny = {ry_ff[fvsl_pkg::RW-1], ry_ff};
      end
      last_x_in = last_x_ff;
      last_y_in = last_y_ff;
      if (state_ff == fvsl_pkg::ST_UPDATE && out_free) begin
         last_x_in = fvsl_pkg::sat16(nx);
         last_y_in = fvsl_pkg::sat16(ny);
      end
      max_step_in  = csr_wr_en ? csr_wr_data : max_step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (state_ff == fvsl_pkg::ST_UPDATE && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fvsl_pkg::ST_IDLE;
         max_step_ff  <= STEP_RESET;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         rq_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         max_step_ff  <= max_step_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == fvsl_pkg::ST_DIFF) begin
            rq_ff <= '0;
         end else if (state_ff == fvsl_pkg::ST_ROOT_WAIT && rd_status.done) begin
            rq_ff <= rd_result;
         end
      end
      prod_ff <= mul_a * mul_b;
      if (accept) begin
         rate_ff <= req_ang_rate;
      end
      if (state_ff == fvsl_pkg::ST_MUL_Y) begin
         rx_ff <= rnd_val;
         dx_ff <= rnd_val - {{4{last_x_ff[15]}}, last_x_ff};
      end
      if (state_ff == fvsl_pkg::ST_DIFF) begin
         ry_ff <= rnd_val;
         dy_ff <= rnd_val - {{4{last_y_ff[15]}}, last_y_ff};
      end
      if (state_ff == fvsl_pkg::ST_SQ_X) begin
         lim2_ff <= prod_ff[29:0];
      end
      if (state_ff == fvsl_pkg::ST_SQ_Y) begin
         r2_ff <= prod_ff[fvsl_pkg::SW-1:0];
      end
      if (state_ff == fvsl_pkg::ST_SUM) begin
         r2_ff <= r2_ff + prod_ff[fvsl_pkg::SW-1:0];
      end
      if (state_ff == fvsl_pkg::ST_DIVX_WAIT && rd_status.done) begin
         qx_ff <= rd_result[15:0];
      end
      if (state_ff == fvsl_pkg::ST_DIVY_WAIT && rd_status.done) begin
         qy_ff <= rd_result[15:0];
      end
      if (state_ff == fvsl_pkg::ST_UPDATE && out_free) begin
         out_x_ff    <= fvsl_pkg::sat16(nx);
         out_y_ff    <= fvsl_pkg::sat16(ny);
         out_rate_ff <= rate_ff;
      end
   end

   assign req_stall        = (state_ff != fvsl_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vel_x_out    = out_x_ff;
   assign rsp_vel_y_out    = out_y_ff;
   assign rsp_ang_rate_out = out_rate_ff;

   `FVSL_ASSERT_IMP(a_quot_fits, clock, reset, rd_status.done && (state_ff == fvsl_pkg::ST_DIVX_WAIT || state_ff == fvsl_pkg::ST_DIVY_WAIT), rd_result[fvsl_pkg::QW-1:16] == '0, "scaled step quotient overflow")
   `FVSL_ASSERT(a_state_upd, clock, reset, $stable(last_x_ff) || $past(reset) || $past(state_ff == fvsl_pkg::ST_UPDATE), "stored velocity changed outside update")
   `FVSL_ASSERT_IMP(a_root_nonzero, clock, reset, state_ff == fvsl_pkg::ST_MX, rq_ff != '0, "limited path with zero root")

endmodule
